// ===== src/mgc_pkg.sv =====
`timescale 1ns / 1ps

package mgc_pkg;

  localparam int ID_W   = 6;
  localparam int MASK_W = 8;
  localparam int KCNT_W = 7;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  typedef struct packed {
    logic [KCNT_W-1:0] kept_count;
    logic              overflow;
    logic              kept;
    logic [MASK_W-1:0] mask;
    logic [ID_W-1:0]   group_id;
    logic              last;
  } out_beat_t;

endpackage

// ===== src/mgc_ram.sv =====
`timescale 1ns / 1ps

module mgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/masked_group_compaction.sv =====
`timescale 1ns / 1ps

// Loads a list of (group id, ray mask) beats, one per cycle, into an id RAM and
// a mask RAM of MAX_GROUPS entries; loads beyond capacity are dropped and
// flagged. The beat with tlast starts an in-place two-pointer partition that
// moves groups with a nonzero mask to the front, then every loaded entry is
// sent out in its new order with its kept flag, the kept count on the last
// beat. A front pointer step reads then checks an entry, a back pointer step
// decrements, reads then checks, and a swap writes the back entry to the front
// then the front id to the back, as both RAMs have one registered read port;
// emission reads each result, then loads it into the output register. The
// input is not ready from the tlast beat until the last result is in it.
module masked_group_compaction #(
  parameter int MAX_GROUPS = 64,
  parameter int GROUP_SIZE = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [5:0] group_id, [13:6] ray_mask, [15:14] zero
  input  logic [mgc_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [5:0] out_group_id, [13:6] out_mask, [20:14] kept_count, [23:21] zero
  output logic [mgc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] kept, [1] overflow
  output logic [mgc_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                out_tlast
);

  localparam int AW = $clog2(MAX_GROUPS);
  localparam int CW = $clog2(MAX_GROUPS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_GROUPS);
  localparam logic [mgc_pkg::MASK_W-1:0] LANE_MASK =
    (GROUP_SIZE >= 8) ? 8'hFF : 8'((1 << GROUP_SIZE) - 1);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_FRD  = 4'd1;
  localparam logic [3:0] S_FCHK = 4'd2;
  localparam logic [3:0] S_BDEC = 4'd3;
  localparam logic [3:0] S_BCHK = 4'd4;
  localparam logic [3:0] S_SW2  = 4'd5;
  localparam logic [3:0] S_ERD  = 4'd6;
  localparam logic [3:0] S_ELD  = 4'd7;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] front_r, front_nxt;
  logic [CW-1:0] back_r, back_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic [mgc_pkg::ID_W-1:0] idf_r, idf_nxt;

  mgc_pkg::out_beat_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic                      id_we, mask_we;
  logic [AW-1:0]             id_waddr, mask_waddr, raddr;
  logic [mgc_pkg::ID_W-1:0]  id_wdata, id_rd;
  logic [mgc_pkg::MASK_W-1:0] mask_wdata, mask_rd;

  logic          in_acc;
  logic [CW-1:0] front_inc, back_dec, idx_inc;

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign front_inc = front_r + CW'(1);
  assign back_dec  = back_r - CW'(1);
  assign idx_inc   = idx_r + CW'(1);

  mgc_ram #(.WIDTH(mgc_pkg::ID_W), .DEPTH(MAX_GROUPS)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .raddr (raddr),
    .rdata (id_rd)
  );

  mgc_ram #(.WIDTH(mgc_pkg::MASK_W), .DEPTH(MAX_GROUPS)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .raddr (raddr),
    .rdata (mask_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    idx_nxt       = idx_r;
    kept_nxt      = kept_r;
    idf_nxt       = idf_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    id_we         = 1'b0;
    mask_we       = 1'b0;
    id_waddr      = fill_r[AW-1:0];
    mask_waddr    = fill_r[AW-1:0];
    id_wdata      = in_tdata[5:0];
    mask_wdata    = in_tdata[13:6] & LANE_MASK;
    raddr         = '0;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (fill_r < MAXC) begin
            id_we    = 1'b1;
            mask_we  = 1'b1;
            fill_nxt = fill_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            front_nxt = '0;
            back_nxt  = (fill_r < MAXC) ? fill_r + CW'(1) : fill_r;
            state_nxt = S_FRD;
          end
        end
      end
      S_FRD: begin
        raddr     = front_r[AW-1:0];
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (mask_rd != '0) begin
          front_nxt = front_inc;
          if (front_inc == back_r) begin
            kept_nxt  = back_r;
            idx_nxt   = '0;
            state_nxt = S_ERD;
          end else begin
            state_nxt = S_FRD;
          end
        end else begin
          idf_nxt   = id_rd;
          state_nxt = S_BDEC;
        end
      end
      S_BDEC: begin
        back_nxt = back_dec;
        raddr    = back_dec[AW-1:0];
        if (front_r == back_dec) begin
          kept_nxt  = back_dec;
          idx_nxt   = '0;
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (mask_rd == '0) begin
          state_nxt = S_BDEC;
        end else begin
          id_we      = 1'b1;
          mask_we    = 1'b1;
          id_waddr   = front_r[AW-1:0];
          mask_waddr = front_r[AW-1:0];
          id_wdata   = id_rd;
          mask_wdata = mask_rd;
          state_nxt  = S_SW2;
        end
      end
      S_SW2: begin
        id_we     = 1'b1;
        id_waddr  = back_r[AW-1:0];
        id_wdata  = idf_r;
        front_nxt = front_inc;
        if (front_inc == back_r) begin
          kept_nxt  = back_r;
          idx_nxt   = '0;
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_FRD;
        end
      end
      S_ERD: begin
        raddr = idx_r[AW-1:0];
        if (!out_valid_r || out_tready) begin
          state_nxt = S_ELD;
        end
      end
      S_ELD: begin
        out_valid_nxt       = 1'b1;
        out_nxt.group_id    = id_rd;
        out_nxt.mask        = mask_rd;
        out_nxt.kept        = (idx_r < kept_r);
        out_nxt.overflow    = ovf_r;
        out_nxt.last        = (idx_inc == fill_r);
        out_nxt.kept_count  = (idx_inc == fill_r) ? mgc_pkg::KCNT_W'(kept_r) : '0;
        idx_nxt             = idx_inc;
        if (idx_inc == fill_r) begin
          fill_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_ERD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      front_r     <= '0;
      back_r      <= '0;
      idx_r       <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      idx_r       <= idx_nxt;
      kept_r      <= kept_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idf_r <= idf_nxt;
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.kept_count, out_r.mask, out_r.group_id};
  assign out_tuser  = {out_r.overflow, out_r.kept};
  assign out_tlast  = out_r.last;

`ifndef SYNTHESIS
  a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= back_r)
    else $error("front pointer passed back pointer");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= MAXC)
    else $error("fill count beyond capacity");

  a_count_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[20:14] == '0))
    else $error("kept count on a beat that is not last");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ELD) |-> !out_valid_r)
    else $error("output register overwritten");

  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_ERD) || (state_r == S_ELD)) |-> (kept_r <= fill_r))
    else $error("kept count above fill count");
`endif

endmodule
